>>> sv/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

    // Field widths of the pixel and of the result.
    localparam int CH_W    = 8;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 16;
    // Sector position scaled by delta: up to six times delta.
    localparam int T_W     = 11;

    // Fixed-point scale factors.
    localparam int HUE_SECTOR_UNITS = 3840;
    localparam int SAT_FULL_SCALE   = 65535;
    localparam int HUE_LIMIT        = 6 * HUE_SECTOR_UNITS;

    // Long division: 24-bit dividend, 8-bit divisor, 16-bit quotient.
    localparam int NUM_W          = 24;
    localparam int QUO_W          = 16;
    localparam int STEPS_PER_STG  = 4;
    localparam int NUM_DIV_STAGES = QUO_W / STEPS_PER_STG;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  value;
    } hsv_t;

    // One division in flight: partial remainder, dividend bits that still
    // shift out at the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] bits;
        logic [CH_W-1:0]  den;
    } div_lane_t;

    // Everything a divider stage carries for one pixel.
    typedef struct packed {
        div_lane_t       sat;
        div_lane_t       hue;
        logic [CH_W-1:0] value;
        logic            hue_zero;
    } div_stage_t;

endpackage

>>> sv/rth_stream_if.sv
`timescale 1ns / 1ps

interface rth_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

>>> sv/rth_div_stage.sv
`timescale 1ns / 1ps

module rth_div_stage
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  div_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output div_stage_t out_data
);

    logic       valid_reg;
    logic       valid_next;
    div_stage_t data_reg;
    div_stage_t data_next;

    // One restoring division step: bring down the next dividend bit,
    // subtract the divisor if it fits, shift the quotient bit in.
    function automatic div_lane_t div_step(input div_lane_t lane);
        logic [CH_W:0] rem_ext;
        div_lane_t     res;
        begin
            res     = lane;
            rem_ext = {lane.rem, lane.bits[QUO_W-1]};
            if (rem_ext >= {1'b0, lane.den})
            begin
                res.rem  = CH_W'(rem_ext - {1'b0, lane.den});
                res.bits = {lane.bits[QUO_W-2:0], 1'b1};
            end
            else
            begin
                res.rem  = rem_ext[CH_W-1:0];
                res.bits = {lane.bits[QUO_W-2:0], 1'b0};
            end
            return res;
        end
    endfunction

    // Four quotient bits for both divisions.
    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < STEPS_PER_STG; i++)
        begin
            data_next.sat = div_step(data_next.sat);
            data_next.hue = div_step(data_next.hue);
        end
    end

    // The stage takes a beat when it is empty or its content moves on.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The partial remainder always stays below a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (data_reg.sat.den != '0) |-> data_reg.sat.rem < data_reg.sat.den)
    else $error("saturation remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (data_reg.hue.den != '0) |-> data_reg.hue.rem < data_reg.hue.den)
    else $error("hue remainder not below divisor");

    // A held beat keeps its stage contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
    else $error("stalled divider stage lost or changed its beat");

endmodule

>>> sv/rgb_to_hsv_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload                               Handshake
// pixel    sink       red, green, blue (8 bits each)        valid / ready
// hsv      source     hue (15), saturation (16), value (8)  valid / ready
//
// One pixel enters per clock unless a stall on hsv has filled every stage.
// Two front stages find max, min and the sector position, then form the
// scaled dividends; four divider stages each resolve 4 quotient bits.
// Reset clears only the stage valid bits; no warm-up pass is needed.
// A stall on hsv holds only the stages that are full: empty stages still
// fill, so the pipeline keeps taking pixels until every stage is occupied.

module rgb_to_hsv_core
    import rth_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rth_stream_if.sink   pixel,
    rth_stream_if.source hsv
);

    // Front stage A: max, min, delta and sector position.
    logic             a_valid_reg;
    logic             a_ready;
    logic [CH_W-1:0]  a_max_reg;
    logic [CH_W-1:0]  a_delta_reg;
    logic [T_W-1:0]   a_t_reg;

    logic [CH_W-1:0]  a_max_next;
    logic [CH_W-1:0]  a_min_next;
    logic [CH_W-1:0]  a_delta_next;
    logic [T_W-1:0]   a_t_next;
    logic [T_W-1:0]   d_ext;

    // Front stage B: dividends ready for the divider.
    logic             b_valid_reg;
    logic             b_ready;
    div_stage_t       b_data_reg;
    div_stage_t       b_data_next;
    logic [NUM_W-1:0] sat_num;
    logic [NUM_W-1:0] hue_num;

    // Divider chain.
    logic       div_valid [NUM_DIV_STAGES+1];
    logic       div_ready [NUM_DIV_STAGES+1];
    div_stage_t div_data  [NUM_DIV_STAGES+1];

    rgb_t px;
    assign px = pixel.data;

    // Largest and smallest channel, then the hue position in delta units.
    always_comb
    begin
        a_max_next = (px.red > px.green) ? px.red : px.green;
        a_max_next = (a_max_next > px.blue) ? a_max_next : px.blue;
        a_min_next = (px.red < px.green) ? px.red : px.green;
        a_min_next = (a_min_next < px.blue) ? a_min_next : px.blue;
        a_delta_next = a_max_next - a_min_next;
        d_ext        = T_W'(a_delta_next);
        priority if (px.red == a_max_next)
        begin
            if (px.green >= px.blue)
                a_t_next = T_W'(px.green - px.blue);
            else
                a_t_next = (d_ext << 2) + (d_ext << 1) - T_W'(px.blue - px.green);
        end
        else if (px.green == a_max_next)
        begin
            a_t_next = (d_ext << 1) + T_W'(px.blue) - T_W'(px.red);
        end
        else
        begin
            a_t_next = (d_ext << 2) + T_W'(px.red) - T_W'(px.green);
        end
    end

    assign a_ready     = !a_valid_reg || b_ready;
    assign pixel.ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pixel.valid)
        begin
            a_max_reg   <= a_max_next;
            a_delta_reg <= a_delta_next;
            a_t_reg     <= a_t_next;
        end
    end

    // Scale by shift and subtract: 65535 * delta and 3840 * t.
    always_comb
    begin
        sat_num = {a_delta_reg, 16'h0000} - NUM_W'(a_delta_reg);
        hue_num = NUM_W'({a_t_reg, 12'h000}) - NUM_W'({a_t_reg, 8'h00});
        b_data_next.sat.rem  = sat_num[NUM_W-1:QUO_W];
        b_data_next.sat.bits = sat_num[QUO_W-1:0];
        b_data_next.sat.den  = a_max_reg;
        b_data_next.hue.rem  = hue_num[NUM_W-1:QUO_W];
        b_data_next.hue.bits = hue_num[QUO_W-1:0];
        b_data_next.hue.den  = a_delta_reg;
        b_data_next.value    = a_max_reg;
        b_data_next.hue_zero = (a_delta_reg == '0);
    end

    assign b_ready = !b_valid_reg || div_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign div_valid[0] = b_valid_reg;
    assign div_data[0]  = b_data_reg;

    // Divider stages, each a register of its own.
    for (genvar s = 0; s < NUM_DIV_STAGES; s++)
    begin : g_div
        rth_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    // Black and grey pixels would divide by zero; force those results.
    assign div_ready[NUM_DIV_STAGES] = hsv.ready;
    assign hsv.valid                 = div_valid[NUM_DIV_STAGES];

    always_comb
    begin
        hsv.data.value      = div_data[NUM_DIV_STAGES].value;
        hsv.data.saturation = (div_data[NUM_DIV_STAGES].value == '0) ? '0
                            : div_data[NUM_DIV_STAGES].sat.bits;
        hsv.data.hue        = div_data[NUM_DIV_STAGES].hue_zero ? '0
                            : div_data[NUM_DIV_STAGES].hue.bits[HUE_W-1:0];
    end

    // Hue stays within one full turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid |-> 32'(hsv.data.hue) < HUE_LIMIT)
    else $error("hue beyond full turn");

    // A colored pixel always has some saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && (hsv.data.hue != '0) |-> hsv.data.saturation != '0)
    else $error("nonzero hue with zero saturation");

    // The quotient of a hue division never overflows its field.
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && !div_data[NUM_DIV_STAGES].hue_zero
            |-> !div_data[NUM_DIV_STAGES].hue.bits[QUO_W-1])
    else $error("hue quotient overflow");

endmodule

>>> tb/rgb_to_hsv_checker.sv
`timescale 1ns / 1ps

// Watches the pixel and hsv channels of the converter. It predicts every
// result and compares each hsv beat with the oldest prediction.
module rgb_to_hsv_checker
    import rth_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    input  logic pixel_ready,
    input  rgb_t pixel_data,
    input  logic hsv_valid,
    input  logic hsv_ready,
    input  hsv_t hsv_data,
    output int   fail_count,
    output int   pending_results
);

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        rgb_t px;
        hsv_t want;
    } conversion_t;

    conversion_t pending_hsv[$];

    // Integer model of the conversion: value is the largest channel,
    // saturation and hue are floored fixed-point quotients.
    function automatic hsv_t hsv_of_pixel(rgb_t px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned hi;
        int unsigned lo;
        int unsigned span;
        int unsigned pos;
        int unsigned sat;
        int unsigned hue;
        hsv_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        span = hi - lo;
        sat = 0;
        hue = 0;
        // A black pixel has no saturation.
        if (hi != 0)
            sat = (SAT_FULL_SCALE * span) / hi;
        // A grey pixel has no hue. Red wins ties, then green, then blue.
        if (span != 0)
        begin
            if (r == hi)
                pos = (g >= b) ? (g - b) : (6 * span - (b - g));
            else if (g == hi)
                pos = 2 * span + b - r;
            else
                pos = 4 * span + r - g;
            hue = (HUE_SECTOR_UNITS * pos) / span;
        end
        res.hue = HUE_W'(hue);
        res.saturation = SAT_W'(sat);
        res.value = CH_W'(hi);
        return res;
    endfunction

    // Compare before queueing, so a result is never matched to a pixel
    // accepted on the same edge.
    always @(posedge clk)
    begin
        conversion_t head;
        if (rst_n)
        begin
            if (hsv_valid && hsv_ready)
            begin
                if (pending_hsv.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] hsv beat with no pixel waiting: hue %0d sat %0d val %0d",
                                 $realtime, hsv_data.hue, hsv_data.saturation,
                                 hsv_data.value);
                end
                else
                begin
                    head = pending_hsv.pop_front();
                    if (hsv_data !== head.want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"[%0t] rgb (%0d,%0d,%0d): expected hue %0d sat %0d ",
                                      "val %0d, got hue %0d sat %0d val %0d"},
                                     $realtime, head.px.red, head.px.green, head.px.blue,
                                     head.want.hue, head.want.saturation, head.want.value,
                                     hsv_data.hue, hsv_data.saturation, hsv_data.value);
                    end
                end
            end
            if (pixel_valid && pixel_ready)
                pending_hsv.push_back('{px: pixel_data, want: hsv_of_pixel(pixel_data)});
        end
        pending_results = pending_hsv.size();
    end

endmodule

>>> tb/tb_rgb_to_hsv_core.sv
`timescale 1ns / 1ps

module tb_rgb_to_hsv_core;

    import rth_pkg::*;

    localparam int RANDOM_PIXELS = 680;
    localparam int DRAIN_CYCLES  = 20;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;

    rgb_t pixel_plan[$];
    int   hsv_cycle;
    int   stall_left;

    rth_stream_if #(.payload_t(rgb_t)) pixel_if ();
    rth_stream_if #(.payload_t(hsv_t)) hsv_if ();

    rgb_to_hsv_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_if.sink),
        .hsv   (hsv_if.source)
    );

    rgb_to_hsv_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_valid     (pixel_if.valid),
        .pixel_ready     (pixel_if.ready),
        .pixel_data      (pixel_if.data),
        .hsv_valid       (hsv_if.valid),
        .hsv_ready       (hsv_if.ready),
        .hsv_data        (hsv_if.data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Random pixel with a bias toward ties, small spreads and saturated
    // channels, so every sector and its boundaries come up often.
    function automatic rgb_t random_pixel();
        rgb_t px;
        logic [7:0] base;
        px = rgb_t'($urandom);
        base = 8'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                // Two channels equal.
                case ($urandom_range(0, 2))
                    0: px.green = px.red;
                    1: px.blue = px.green;
                    default: px.blue = px.red;
                endcase
            end
            3:
                px = '{base, base, base};
            4, 5, 6:
            begin
                // Channels close to one another.
                px.red = base + 8'($urandom_range(0, 3));
                px.green = base + 8'($urandom_range(0, 3));
                px.blue = base + 8'($urandom_range(0, 3));
            end
            7, 8:
            begin
                px.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                px.green = $urandom_range(0, 1) ? 8'd255 : px.green;
                px.blue = $urandom_range(0, 1) ? 8'd0 : px.blue;
            end
            default:
                ;
        endcase
        return px;
    endfunction

    // Receiver: cycles through always ready, random stalls, a fixed
    // rhythm and long stalls.
    always @(negedge clk)
    begin
        hsv_cycle <= hsv_cycle + 1;
        case ((hsv_cycle / 97) % 4)
            0:
                hsv_if.ready <= 1'b1;
            1:
                hsv_if.ready <= ($urandom_range(0, 9) < 7);
            2:
                hsv_if.ready <= ((hsv_cycle % 5) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left <= stall_left - 1;
                    hsv_if.ready <= 1'b0;
                end
                else
                begin
                    stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : 0;
                    hsv_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // Stimulus and verdict.
    initial
    begin
        int burst_left;
        int gap;
        rst_n = 1'b0;
        pixel_if.valid = 1'b0;
        pixel_if.data = '0;
        hsv_if.ready = 1'b0;
        hsv_cycle = 0;
        stall_left = 0;
        burst_left = 0;

        // Black, white, grey, primaries, secondaries where red or green wins
        // the tie, hue wrap below zero, spreads of one and bit patterns.
        pixel_plan.push_back('{8'd0, 8'd0, 8'd0});
        pixel_plan.push_back('{8'd255, 8'd255, 8'd255});
        pixel_plan.push_back('{8'd128, 8'd128, 8'd128});
        pixel_plan.push_back('{8'd255, 8'd0, 8'd0});
        pixel_plan.push_back('{8'd0, 8'd255, 8'd0});
        pixel_plan.push_back('{8'd0, 8'd0, 8'd255});
        pixel_plan.push_back('{8'd255, 8'd255, 8'd0});
        pixel_plan.push_back('{8'd0, 8'd255, 8'd255});
        pixel_plan.push_back('{8'd255, 8'd0, 8'd255});
        pixel_plan.push_back('{8'd255, 8'd0, 8'd1});
        pixel_plan.push_back('{8'd255, 8'd1, 8'd0});
        pixel_plan.push_back('{8'd10, 8'd200, 8'd50});
        pixel_plan.push_back('{8'd50, 8'd200, 8'd10});
        pixel_plan.push_back('{8'd1, 8'd2, 8'd255});
        pixel_plan.push_back('{8'd2, 8'd1, 8'd255});
        pixel_plan.push_back('{8'd1, 8'd0, 8'd0});
        pixel_plan.push_back('{8'd0, 8'd1, 8'd0});
        pixel_plan.push_back('{8'd0, 8'd0, 8'd1});
        pixel_plan.push_back('{8'd254, 8'd255, 8'd255});
        pixel_plan.push_back('{8'd255, 8'd254, 8'd255});
        pixel_plan.push_back('{8'd170, 8'd85, 8'd170});
        pixel_plan.push_back('{8'd85, 8'd170, 8'd85});
        for (int i = 0; i < RANDOM_PIXELS; i++)
            pixel_plan.push_back(random_pixel());

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Send in bursts of random length with random gaps between them.
        foreach (pixel_plan[i])
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 100)
                                                         : $urandom_range(1, 30);
                if (gap > 0)
                begin
                    pixel_if.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            pixel_if.valid <= 1'b1;
            pixel_if.data <= pixel_plan[i];
            @(posedge clk);
            while (!pixel_if.ready)
                @(posedge clk);
            @(negedge clk);
        end
        pixel_if.valid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/rth_pkg.sv
sv/rth_stream_if.sv
sv/rth_div_stage.sv
sv/rgb_to_hsv_core.sv
tb/rgb_to_hsv_checker.sv
tb/tb_rgb_to_hsv_core.sv
